// ===== hw/rtl/ljpe_pkg.sv =====
// Shared constants and types of the Lennard-Jones pair energy unit.
// No dependencies; imported by ljpe_div and lennard_jones_pair_energy.
package ljpe_pkg;

    localparam int TYPE_COUNT = 4;
    localparam int PAIR_COUNT = TYPE_COUNT * TYPE_COUNT;
    localparam int ADDR_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
    localparam int TYPE_W     = 2;
    localparam int IN_W       = 168;
    localparam int OUT_W      = 64;
    localparam int WORD_W     = 128;
    localparam int DIV_W      = 98;
    localparam int Q_W        = 64;
    localparam int DIV_LAT    = Q_W + 1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SHIFT = 2'd1;
    localparam logic [1:0] MODE_XPLOR = 2'd2;

    localparam logic [63:0] E_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] E_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        bad;
        logic [31:0] eps;
        logic        shift;
        logic        xplor;
        logic        r2zero;
        logic        czero;
        logic        numzero;
        logic        denzero;
        logic        neg_wa;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] f;
        logic        fovf;
    } post_t;

    typedef struct packed {
        logic [63:0] e;
        logic        flag;
    } energy_t;

endpackage

// ===== hw/rtl/ljpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ljpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/ljpe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ljpe_pkg for the remainder and quotient widths.
module ljpe_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ljpe_pkg::DIV_W-1:0] rem_in,
    input  logic [ljpe_pkg::Q_W-1:0]   bits_in,
    input  logic [ljpe_pkg::DIV_W-1:0] den_in,
    output logic [ljpe_pkg::Q_W-1:0]   quo,
    output logic                       ovf
);
    import ljpe_pkg::*;

    logic [DIV_W-1:0] rem_reg  [0:Q_W-1];
    logic [DIV_W-1:0] den_reg  [0:Q_W-1];
    logic [Q_W-1:0]   bits_reg [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg  [0:Q_W];
    logic             ovf_reg  [0:Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_in;
            den_reg[0]  <= den_in;
            bits_reg[0] <= bits_in;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= rem_in >= den_in;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= Q_W; s++)
        begin : g_step
            logic [DIV_W-1:0] trial;
            logic             take;

            always_comb
            begin
                trial = {rem_reg[s-1][DIV_W-2:0], bits_reg[s-1][Q_W-1]};
                take  = trial >= den_reg[s-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[s] <= {quo_reg[s-1][Q_W-2:0], take};
                    ovf_reg[s] <= ovf_reg[s-1];
                end
            end

            if (s < Q_W)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s]  <= take ? trial - den_reg[s-1] : trial;
                        den_reg[s]  <= den_reg[s-1];
                        bits_reg[s] <= {bits_reg[s-1][Q_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

// ===== hw/rtl/lennard_jones_pair_energy.sv =====
// Lennard-Jones pair energy unit: parameter RAM, cube and smoothing products,
// pipelined dividers and energy post-processing. Uses ljpe_pkg, ljpe_ram, ljpe_div.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: types, distance, params; tuser: action
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pair_energy; tuser: saturated
//  cfg       in   cfg_valid/cfg_ready          cfg_data: mode
//
// One item per cycle while no output stall holds the pipeline; a query result's delay
// is set by the 64-step restoring divider pipelines plus the multiply stages.
// A load writes the parameter RAM at its transfer and yields no result.
// Reset clears the stage valids, the output valid and the mode; no RAM clear.
// An output stall freezes the pipeline only when its last stage holds a result.
module lennard_jones_pair_energy (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // type_i, type_j, dist_sq, four_epsilon, sigma_pow6, cutoff_sq, switch_on_sq, pad
    input  logic [ljpe_pkg::IN_W-1:0]  s_axis_tdata,
    // action
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // pair_energy
    output logic [ljpe_pkg::OUT_W-1:0] m_axis_tdata,
    // saturated
    output logic                       m_axis_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_data
);
    import ljpe_pkg::*;

    localparam int ST_DIV_OUT = 4 + DIV_LAT;
    localparam int NSTG       = ST_DIV_OUT + 8;

    logic [1:0]        mode_reg;
    logic [NSTG-1:0]   vld_reg;
    logic              adv;
    logic              out_load;
    logic              in_fire;
    logic [TYPE_W-1:0] ti, tj, t_lo, t_hi;
    logic              type_ok;
    logic [ADDR_W-1:0] addr;
    logic              ram_we;
    logic [WORD_W-1:0] ram_q;
    logic [31:0]       eps_m, s6_m, c_m, on_m;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign out_load      = m_axis_tready || !m_axis_tvalid;
    assign adv           = out_load || !vld_reg[NSTG-1];
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;

    always_comb
    begin
        ti      = s_axis_tdata[1:0];
        tj      = s_axis_tdata[3:2];
        type_ok = (32'(ti) < TYPE_COUNT) && (32'(tj) < TYPE_COUNT);
        t_lo    = (ti < tj) ? ti : tj;
        t_hi    = (ti < tj) ? tj : ti;
        addr    = ADDR_W'(32'(t_lo) * TYPE_COUNT + 32'(t_hi));
        ram_we  = in_fire && (s_axis_tuser == ACT_LOAD) && type_ok;
    end

    ljpe_ram #(
        .WIDTH(WORD_W),
        .DEPTH(PAIR_COUNT)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr),
        .wdata(s_axis_tdata[163:36]),
        .re   (adv),
        .raddr(addr),
        .rdata(ram_q)
    );

    assign eps_m = ram_q[31:0];
    assign s6_m  = ram_q[63:32];
    assign c_m   = ram_q[95:64];
    assign on_m  = ram_q[127:96];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_fire && (s_axis_tuser == ACT_QUERY)};
        end
    end

    // stage 1
    logic        s1_bad_reg;
    logic [31:0] s1_r2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bad_reg <= !type_ok;
            s1_r2_reg  <= s_axis_tdata[35:4];
        end
    end

    // stage 2
    logic [32:0] a_s, b_s, a_mag, b_mag;
    logic [34:0] w_s, w_mag;
    side_t       s2_side_next;
    side_t       s2_side_reg;
    logic [31:0] s2_s6_reg, s2_r2_reg, s2_c_reg, s2_aa_reg, s2_bb_reg;
    logic [33:0] s2_ww_reg;
    logic [63:0] s2_r2sq_reg, s2_csq_reg;

    always_comb
    begin
        a_s   = {1'b0, c_m} - {1'b0, on_m};
        b_s   = {1'b0, c_m} - {1'b0, s1_r2_reg};
        w_s   = {3'b0, c_m} + {2'b0, s1_r2_reg, 1'b0} - {3'b0, on_m} - {2'b0, on_m, 1'b0};
        a_mag = a_s[32] ? -a_s : a_s;
        b_mag = b_s[32] ? -b_s : b_s;
        w_mag = w_s[34] ? -w_s : w_s;
        s2_side_next.bad     = s1_bad_reg;
        s2_side_next.eps     = eps_m;
        s2_side_next.shift   = (mode_reg == MODE_SHIFT) || ((mode_reg == MODE_XPLOR) && (on_m >= c_m));
        s2_side_next.xplor   = (mode_reg == MODE_XPLOR) && (s1_r2_reg > on_m);
        s2_side_next.r2zero  = s1_r2_reg == 32'd0;
        s2_side_next.czero   = c_m == 32'd0;
        s2_side_next.numzero = (b_s == 33'd0) || (w_s == 35'd0);
        s2_side_next.denzero = a_s == 33'd0;
        s2_side_next.neg_wa  = w_s[34] ^ a_s[32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_s6_reg   <= s6_m;
            s2_r2_reg   <= s1_r2_reg;
            s2_c_reg    <= c_m;
            s2_aa_reg   <= a_mag[31:0];
            s2_bb_reg   <= b_mag[31:0];
            s2_ww_reg   <= w_mag[33:0];
            s2_r2sq_reg <= 64'(s1_r2_reg) * 64'(s1_r2_reg);
            s2_csq_reg  <= 64'(c_m) * 64'(c_m);
        end
    end

    // stage 3
    side_t       s3_side_reg;
    logic [31:0] s3_s6_reg, s3_aa_reg;
    logic [33:0] s3_ww_reg;
    logic [63:0] s3_r2c_lo_reg, s3_r2c_hi_reg, s3_cc_lo_reg, s3_cc_hi_reg;
    logic [63:0] s3_aa2_reg, s3_bb2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg   <= s2_side_reg;
            s3_s6_reg     <= s2_s6_reg;
            s3_aa_reg     <= s2_aa_reg;
            s3_ww_reg     <= s2_ww_reg;
            s3_r2c_lo_reg <= 64'(s2_r2sq_reg[31:0]) * 64'(s2_r2_reg);
            s3_r2c_hi_reg <= 64'(s2_r2sq_reg[63:32]) * 64'(s2_r2_reg);
            s3_cc_lo_reg  <= 64'(s2_csq_reg[31:0]) * 64'(s2_c_reg);
            s3_cc_hi_reg  <= 64'(s2_csq_reg[63:32]) * 64'(s2_c_reg);
            s3_aa2_reg    <= 64'(s2_aa_reg) * 64'(s2_aa_reg);
            s3_bb2_reg    <= 64'(s2_bb_reg) * 64'(s2_bb_reg);
        end
    end

    // stage 4
    side_t       s4_side_reg;
    logic [31:0] s4_s6_reg;
    logic [95:0] s4_cube_reg [0:1];
    logic [63:0] s4_den_lo_reg, s4_den_hi_reg;
    logic [65:0] s4_num_lo_reg, s4_num_hi_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg    <= s3_side_reg;
            s4_s6_reg      <= s3_s6_reg;
            s4_cube_reg[0] <= 96'(s3_r2c_lo_reg) + {s3_r2c_hi_reg, 32'b0};
            s4_cube_reg[1] <= 96'(s3_cc_lo_reg) + {s3_cc_hi_reg, 32'b0};
            s4_den_lo_reg  <= 64'(s3_aa2_reg[31:0]) * 64'(s3_aa_reg);
            s4_den_hi_reg  <= 64'(s3_aa2_reg[63:32]) * 64'(s3_aa_reg);
            s4_num_lo_reg  <= 66'(s3_bb2_reg[31:0]) * 66'(s3_ww_reg);
            s4_num_hi_reg  <= 66'(s3_bb2_reg[63:32]) * 66'(s3_ww_reg);
        end
    end

    // stage 5
    side_t       s5_side_reg;
    logic [31:0] s5_s6_reg;
    logic [95:0] s5_cube_reg [0:1];
    logic [95:0] s5_den_reg;
    logic [97:0] s5_num_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg    <= s4_side_reg;
            s5_s6_reg      <= s4_s6_reg;
            s5_cube_reg[0] <= s4_cube_reg[0];
            s5_cube_reg[1] <= s4_cube_reg[1];
            s5_den_reg     <= 96'(s4_den_lo_reg) + {s4_den_hi_reg, 32'b0};
            s5_num_reg     <= 98'(s4_num_lo_reg) + {s4_num_hi_reg, 32'b0};
        end
    end

    // smoothing factor divider and side delay
    logic [Q_W-1:0] f_quo;
    logic           f_ovf;
    side_t          side_dly_reg [0:DIV_LAT-1];
    post_t          post_reg [0:6];

    ljpe_div u_sdiv (
        .clk    (clk),
        .en     (adv),
        .rem_in (DIV_W'(s5_num_reg[97:32])),
        .bits_in({s5_num_reg[31:0], 32'b0}),
        .den_in (DIV_W'(s5_den_reg)),
        .quo    (f_quo),
        .ovf    (f_ovf)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_dly_reg[0] <= s5_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
            post_reg[0].side <= side_dly_reg[DIV_LAT-1];
            post_reg[0].f    <= f_quo;
            post_reg[0].fovf <= f_ovf;
            for (int i = 1; i < 7; i++)
            begin
                post_reg[i] <= post_reg[i-1];
            end
        end
    end

    // energy lanes: at r2 and at the cutoff
    energy_t lane_e [0:1];

    genvar l;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic [Q_W-1:0] quo;
            logic           dovf;
            logic [63:0]    x_reg, d_reg;
            logic           negx_reg [1:4];
            logic           dovf_reg [1:2];
            logic [63:0]    p00_reg, p01_reg, p10_reg, p11_reg;
            logic [127:0]   t_sum;
            logic [63:0]    m1_reg;
            logic           ovf3_reg, ovf4_reg;
            logic [63:0]    m2lo_reg, m2hi_reg;
            logic [95:0]    p_sum;
            logic [63:0]    mag;
            logic           zero;
            energy_t        e_next;
            energy_t        e_reg;

            ljpe_div u_div (
                .clk    (clk),
                .en     (adv),
                .rem_in (DIV_W'({s5_s6_reg, 24'b0})),
                .bits_in('0),
                .den_in (DIV_W'(s5_cube_reg[l])),
                .quo    (quo),
                .ovf    (dovf)
            );

            always_comb
            begin
                t_sum = 128'(p00_reg) + 128'({p01_reg, 32'b0}) + 128'({p10_reg, 32'b0})
                      + {p11_reg, 64'b0};
                p_sum = 96'(m2lo_reg) + {m2hi_reg, 32'b0};
                mag   = {1'b0, p_sum[78:16]};
                zero  = (l == 0) ? post_reg[3].side.r2zero : post_reg[3].side.czero;
                if (zero)
                begin
                    e_next = '{e: E_MAX, flag: 1'b1};
                end
                else if (ovf4_reg)
                begin
                    if (post_reg[3].side.eps == 32'd0)
                    begin
                        e_next = '{e: 64'd0, flag: 1'b0};
                    end
                    else
                    begin
                        e_next = '{e: E_MAX, flag: 1'b1};
                    end
                end
                else if (p_sum[95:79] != 17'd0)
                begin
                    e_next = '{e: E_MAX, flag: 1'b1};
                end
                else
                begin
                    e_next = '{e: negx_reg[4] ? -mag : mag, flag: 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg       <= quo;
                    negx_reg[1] <= quo[63:32] == 32'd0;
                    d_reg       <= (quo[63:32] == 32'd0) ? 64'h1_0000_0000 - quo
                                                         : quo - 64'h1_0000_0000;
                    dovf_reg[1] <= dovf;
                    p00_reg     <= 64'(x_reg[31:0]) * 64'(d_reg[31:0]);
                    p01_reg     <= 64'(x_reg[31:0]) * 64'(d_reg[63:32]);
                    p10_reg     <= 64'(x_reg[63:32]) * 64'(d_reg[31:0]);
                    p11_reg     <= 64'(x_reg[63:32]) * 64'(d_reg[63:32]);
                    negx_reg[2] <= negx_reg[1];
                    dovf_reg[2] <= dovf_reg[1];
                    m1_reg      <= t_sum[95:32];
                    ovf3_reg    <= dovf_reg[2] || (t_sum[127:96] != 32'd0);
                    negx_reg[3] <= negx_reg[2];
                    m2lo_reg    <= 64'(m1_reg[31:0]) * 64'(post_reg[2].side.eps);
                    m2hi_reg    <= 64'(m1_reg[63:32]) * 64'(post_reg[2].side.eps);
                    ovf4_reg    <= ovf3_reg;
                    negx_reg[4] <= negx_reg[3];
                    e_reg       <= e_next;
                end
            end

            assign lane_e[l] = e_reg;
        end
    endgenerate

    // stage 6: shift at cutoff
    logic [64:0] diff;
    logic [63:0] t6_e_next, t6_e_reg;
    logic        t6_flag_next, t6_flag_reg;

    always_comb
    begin
        diff = {lane_e[0].e[63], lane_e[0].e} - {lane_e[1].e[63], lane_e[1].e};
        t6_e_next    = lane_e[0].e;
        t6_flag_next = lane_e[0].flag;
        if (post_reg[4].side.shift)
        begin
            t6_flag_next = 1'b1;
            if (lane_e[0].flag && lane_e[1].flag)
            begin
                t6_e_next = 64'd0;
            end
            else if (lane_e[0].flag)
            begin
                t6_e_next = E_MAX;
            end
            else if (lane_e[1].flag)
            begin
                t6_e_next = E_MIN;
            end
            else if (diff[64] != diff[63])
            begin
                t6_e_next = diff[64] ? E_MIN : E_MAX;
            end
            else
            begin
                t6_e_next    = diff[63:0];
                t6_flag_next = 1'b0;
            end
        end
    end

    // stage 7: |E| times smoothing factor, partial products
    logic [63:0] emag;
    logic [63:0] t7_e_reg;
    logic        t7_flag_reg;
    logic [63:0] q00_reg, q01_reg, q10_reg, q11_reg;

    assign emag = t6_e_reg[63] ? -t6_e_reg : t6_e_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t6_e_reg    <= t6_e_next;
            t6_flag_reg <= t6_flag_next;
            t7_e_reg    <= t6_e_reg;
            t7_flag_reg <= t6_flag_reg;
            q00_reg     <= 64'(emag[31:0]) * 64'(post_reg[5].f[31:0]);
            q01_reg     <= 64'(emag[31:0]) * 64'(post_reg[5].f[63:32]);
            q10_reg     <= 64'(emag[63:32]) * 64'(post_reg[5].f[31:0]);
            q11_reg     <= 64'(emag[63:32]) * 64'(post_reg[5].f[63:32]);
        end
    end

    // output selection
    logic [127:0] prod;
    logic [63:0]  m_mag, sat_e, res_e;
    logic         res_neg, res_flag, ezero;
    side_t        sd;

    always_comb
    begin
        sd       = post_reg[6].side;
        prod     = 128'(q00_reg) + 128'({q01_reg, 32'b0}) + 128'({q10_reg, 32'b0})
                 + {q11_reg, 64'b0};
        m_mag    = prod[95:32];
        res_neg  = t7_e_reg[63] ^ sd.neg_wa;
        sat_e    = res_neg ? E_MIN : E_MAX;
        ezero    = t7_e_reg == 64'd0;
        res_e    = t7_e_reg;
        res_flag = t7_flag_reg;
        if (sd.bad)
        begin
            res_e    = 64'd0;
            res_flag = 1'b1;
        end
        else if (sd.xplor)
        begin
            if (sd.denzero)
            begin
                res_flag = 1'b1;
                res_e    = (ezero || sd.numzero) ? 64'd0 : sat_e;
            end
            else if (sd.numzero || ezero)
            begin
                res_e = 64'd0;
            end
            else if (post_reg[6].fovf || (prod[127:95] != 33'd0))
            begin
                res_flag = 1'b1;
                res_e    = sat_e;
            end
            else
            begin
                res_e = res_neg ? -m_mag : m_mag;
            end
        end
    end

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_e;
            out_flag_reg <= res_flag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_load_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD)) |=> !vld_reg[0])
        else $error("load transfer entered the result pipeline");

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(vld_reg[NSTG-1]))
        else $error("result appeared without a finished item");
`endif

endmodule
